// ===== hw/rtl/rhc_pkg.sv =====
// shared constants for the rgb to hsv converter
package rhc_pkg;

   localparam int CHANNEL_BITS_DEF = 8;
   localparam int PIXEL_BITS       = 8;
   localparam int RESULT_BITS      = 15;

   localparam int HUE_SECTOR = 3840;
   localparam int HUE_FULL   = 23040;
   localparam int PCT_SCALE  = 25600;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 32;

endpackage

// ===== hw/rtl/rhc_fifo.sv =====
// small register queue used between the converter stages and on the result side
module rhc_fifo
   import rhc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = MID_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/rhc_front.sv =====
// front stage: takes pixels, finds max, min, spread, hue sector term and gray flag
module rhc_front
   import rhc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [PIXEL_BITS-1:0]     req_red_in,
   input  logic [PIXEL_BITS-1:0]     req_green_in,
   input  logic [PIXEL_BITS-1:0]     req_blue_in,
   output logic                      job_push,
   input  logic                      job_full,
   output logic [3*CHANNEL_BITS+3:0] job_data
);

   localparam int CB  = CHANNEL_BITS;
   localparam int K_W = CB + 3;

   logic          valid_ff, valid_in;
   logic [CB-1:0] red_ff, green_ff, blue_ff;
   logic [CB-1:0] red_c, green_c, blue_c;
   logic          accept;
   logic [CB-1:0] max_v, min_v, spread;
   logic [K_W-1:0] term;
   logic          gray;

   if (CB <= PIXEL_BITS) begin : g_narrow
      assign red_c   = req_red_in[CB-1:0];
      assign green_c = req_green_in[CB-1:0];
      assign blue_c  = req_blue_in[CB-1:0];
   end else begin : g_wide
      assign red_c   = {{(CB-PIXEL_BITS){1'b0}}, req_red_in};
      assign green_c = {{(CB-PIXEL_BITS){1'b0}}, req_green_in};
      assign blue_c  = {{(CB-PIXEL_BITS){1'b0}}, req_blue_in};
   end

   assign req_full = valid_ff & job_full;
   assign accept   = req_push & ~req_full;
   assign valid_in = accept | (valid_ff & job_full);
   assign job_push = valid_ff & ~job_full;

   always_comb begin
      max_v = (red_ff > green_ff) ? red_ff : green_ff;
      min_v = (red_ff < green_ff) ? red_ff : green_ff;
      if (blue_ff > max_v) begin
         max_v = blue_ff;
      end
      if (blue_ff < min_v) begin
         min_v = blue_ff;
      end
      spread = max_v - min_v;
      gray   = (spread == '0);
      // sector position times spread, kept non-negative
      priority if (red_ff == max_v) begin
         if (green_ff >= blue_ff) begin
            term = K_W'(green_ff) - K_W'(blue_ff);
         end else begin
            term = K_W'(spread) * K_W'(6) - (K_W'(blue_ff) - K_W'(green_ff));
         end
      end else if (green_ff == max_v) begin
         term = K_W'({spread, 1'b0}) + K_W'(blue_ff) - K_W'(red_ff);
      end else begin
         term = K_W'({spread, 2'b00}) + K_W'(red_ff) - K_W'(green_ff);
      end
   end

   assign job_data = {term, spread, max_v, gray};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= red_c;
         green_ff <= green_c;
         blue_ff  <= blue_c;
      end
   end

endmodule

// ===== hw/rtl/rhc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, quotient known to fit
module rhc_div
   import rhc_pkg::*;
#(
   parameter int DEN_W = CHANNEL_BITS_DEF + 1,
   parameter int Q_W   = RESULT_BITS
) (
   input  logic                   clock,
   input  logic [DEN_W+Q_W-1:0]   num,
   input  logic [DEN_W-1:0]       den,
   output logic [Q_W-1:0]         quot
);

   localparam int NUM_W = DEN_W + Q_W;

   logic [DEN_W-1:0] rem_ff  [Q_W];
   logic [Q_W-1:0]   low_ff  [Q_W];
   logic [Q_W-1:0]   quot_ff [Q_W];
   logic [DEN_W-1:0] den_ff  [Q_W];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      logic [DEN_W-1:0] rem_i;
      logic [Q_W-1:0]   low_i;
      logic [Q_W-1:0]   quot_i;
      logic [DEN_W-1:0] den_i;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      if (s == 0) begin : g_first
         assign rem_i  = num[NUM_W-1:Q_W];
         assign low_i  = num[Q_W-1:0];
         assign quot_i = '0;
         assign den_i  = den;
      end else begin : g_next
         assign rem_i  = rem_ff[s-1];
         assign low_i  = low_ff[s-1];
         assign quot_i = quot_ff[s-1];
         assign den_i  = den_ff[s-1];
      end

      assign trial  = {rem_i, low_i[Q_W-1]};
      assign ge     = (trial >= {1'b0, den_i});
      assign diff   = trial - {1'b0, den_i};
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         low_ff[s]  <= {low_i[Q_W-2:0], 1'b0};
         quot_ff[s] <= {quot_i[Q_W-2:0], ge};
         den_ff[s]  <= den_i;
      end
   end

   assign quot = quot_ff[Q_W-1];

endmodule

// ===== hw/rtl/rhc_back.sv =====
// back stage: issues jobs against output credit, divides and finishes hue, saturation, value
module rhc_back
   import rhc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_empty,
   input  logic [3*CHANNEL_BITS+3:0] job_data,
   output logic                      job_pop,
   input  logic                      out_pop,
   output logic                      out_push,
   output logic [3*RESULT_BITS:0]    out_data
);

   localparam int CB    = CHANNEL_BITS;
   localparam int K_W   = CB + 3;
   localparam int DEN_W = CB + 1;
   localparam int Q_W   = RESULT_BITS;
   localparam int NUM_W = DEN_W + Q_W;
   localparam int CR_W  = $clog2(OUT_DEPTH + 1);
   localparam int RCP_W = NUM_W + 1;
   localparam int PROD_W = NUM_W + RCP_W;
   localparam int VAL_SHIFT = NUM_W + CB + 1;
   localparam longint unsigned VAL_DIV = (64'd1 << (CB + 1)) - 64'd2;
   localparam logic [CR_W-1:0]  CREDIT_MAX = CR_W'(OUT_DEPTH);
   localparam logic [RCP_W-1:0] VAL_RECIP  =
      RCP_W'(((64'd1 << VAL_SHIFT) + VAL_DIV - 64'd1) / VAL_DIV);
   localparam logic [Q_W-1:0]   HUE_WRAP   = Q_W'(HUE_FULL);

   logic [K_W-1:0]   term;
   logic [CB-1:0]    spread, max_v;
   logic             gray;

   logic             v0_ff;
   logic             gray0_ff;
   logic [NUM_W-1:0] hue_num_ff, sat_num_ff, val_num_ff;
   logic [DEN_W-1:0] hue_den_ff, sat_den_ff;

   logic [Q_W-1:0]   valid_pipe_ff;
   logic [Q_W-1:0]   gray_pipe_ff;
   logic [CR_W-1:0]  credit_ff, credit_in;

   logic [PROD_W-1:0] val_prod_ff;
   logic [Q_W-1:0]    val_pipe_ff [Q_W-1];

   logic [Q_W-1:0]   hue_q, sat_q, val_q, hue_w;
   logic             gray_out;

   assign {term, spread, max_v, gray} = job_data;

   // reserve a slot in the result queue for every issued job
   assign job_pop = ~job_empty & (credit_ff < CREDIT_MAX);

   always_comb begin
      credit_in = credit_ff;
      unique case ({job_pop, out_pop})
         2'b10:   credit_in = credit_ff + 1'b1;
         2'b01:   credit_in = credit_ff - 1'b1;
         default: credit_in = credit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff     <= '0;
         v0_ff         <= 1'b0;
         valid_pipe_ff <= '0;
      end else begin
         credit_ff     <= credit_in;
         v0_ff         <= job_pop;
         valid_pipe_ff <= {valid_pipe_ff[Q_W-2:0], v0_ff};
      end
   end

   // numerators carry the round-half-up term: 2*num + den over 2*den
   always_ff @(posedge clock) begin
      hue_num_ff <= NUM_W'(term) * NUM_W'(2 * HUE_SECTOR) + NUM_W'(spread);
      sat_num_ff <= NUM_W'(spread) * NUM_W'(2 * PCT_SCALE) + NUM_W'(max_v);
      val_num_ff <= NUM_W'(max_v) * NUM_W'(2 * PCT_SCALE) + NUM_W'({CB{1'b1}});
      hue_den_ff <= {spread, 1'b0};
      sat_den_ff <= {max_v, 1'b0};
      gray0_ff   <= gray;
      gray_pipe_ff <= {gray_pipe_ff[Q_W-2:0], gray0_ff};
   end

   rhc_div #(.DEN_W(DEN_W), .Q_W(Q_W)) u_hue_div (
      .clock (clock),
      .num   (hue_num_ff),
      .den   (hue_den_ff),
      .quot  (hue_q)
   );

   rhc_div #(.DEN_W(DEN_W), .Q_W(Q_W)) u_sat_div (
      .clock (clock),
      .num   (sat_num_ff),
      .den   (sat_den_ff),
      .quot  (sat_q)
   );

   // value divides by the constant full scale: reciprocal multiply, then delay to line up
   always_ff @(posedge clock) begin
      val_prod_ff    <= PROD_W'(val_num_ff) * PROD_W'(VAL_RECIP);
      val_pipe_ff[0] <= val_prod_ff[VAL_SHIFT +: Q_W];
      for (int k = 1; k < Q_W - 1; k++) begin
         val_pipe_ff[k] <= val_pipe_ff[k-1];
      end
   end

   assign val_q = val_pipe_ff[Q_W-2];

   assign gray_out = gray_pipe_ff[Q_W-1];
   assign hue_w    = (hue_q >= HUE_WRAP) ? hue_q - HUE_WRAP : hue_q;
   assign out_push = valid_pipe_ff[Q_W-1];
   assign out_data = {gray_out ? Q_W'(0) : hue_w,
                      gray_out ? Q_W'(0) : sat_q,
                      val_q,
                      gray_out};

   a_credit_bound : assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CREDIT_MAX)
      else $error("result credit above queue depth");

   a_result_has_credit : assert property (@(posedge clock) disable iff (reset)
      out_push |-> credit_ff != '0)
      else $error("result beat without a reserved slot");

   a_gray_zero : assert property (@(posedge clock) disable iff (reset)
      (out_push && gray_out) |-> (out_data[3*Q_W:2*Q_W+1] == '0 && out_data[2*Q_W:Q_W+1] == '0))
      else $error("gray pixel with nonzero hue or saturation");

endmodule

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
// top level of the rgb to hsv converter: front, job queue, divider back end, result queue
//
// Accepts one pixel per clock and delivers one hue, saturation, value beat per pixel, in
// order. Through an empty pipeline a taken pixel passes the job queue, one numerator
// register, 15 divider stages (one quotient bit per stage) and the write into the result
// queue, in that order, before its result is on the result ports. Throughput
// stays at one pixel per clock while results are popped; the result queue holds 32
// beats, and work is only issued into the dividers when a result slot is reserved for
// it, so a stalled consumer back-pressures through the job queue to full. Hue is in
// 1/64 degree, saturation and value in 1/256 percent, all rounded to nearest; gray
// pixels return hue and saturation 0 with achromatic set.
module rgb_to_hsv_converter
   import rhc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [PIXEL_BITS-1:0]  req_red_in,
   input  logic [PIXEL_BITS-1:0]  req_green_in,
   input  logic [PIXEL_BITS-1:0]  req_blue_in,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [RESULT_BITS-1:0] rsp_hue_out,
   output logic [RESULT_BITS-1:0] rsp_saturation_out,
   output logic [RESULT_BITS-1:0] rsp_value_out,
   output logic                   rsp_achromatic
);

   localparam int JOB_W = 3 * CHANNEL_BITS + 4;
   localparam int OUT_W = 3 * RESULT_BITS + 1;

   logic             job_push, job_full, job_pop, job_empty;
   logic [JOB_W-1:0] job_in_data, job_out_data;
   logic             out_push, out_full, out_pop;
   logic [OUT_W-1:0] out_in_data, out_out_data;

   rhc_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .job_push     (job_push),
      .job_full     (job_full),
      .job_data     (job_in_data)
   );

   rhc_fifo #(.WIDTH(JOB_W), .DEPTH(MID_DEPTH)) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   rhc_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .out_pop   (out_pop),
      .out_push  (out_push),
      .out_data  (out_in_data)
   );

   assign out_pop = rsp_pop & ~rsp_empty;

   rhc_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_in_data),
      .full      (out_full),
      .pop       (out_pop),
      .pop_data  (out_out_data),
      .empty     (rsp_empty)
   );

   assign {rsp_hue_out, rsp_saturation_out, rsp_value_out, rsp_achromatic} = out_out_data;

   a_no_result_overflow : assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result beat pushed into a full result queue");

endmodule
